[rtl/core/cat_pkg.sv]
// Package with the shared types and constants of the compacting array table.
`timescale 1ns / 1ps

package cat_pkg;

  localparam int VAL_W   = 32;
  localparam int IDX_W   = 4;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DUMP   = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_BADINDEX = 3'd3,
    STAT_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUMP,
    S_SEARCH,
    S_DEL_FETCH,
    S_DEL_SHIFT,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
  } cmd_t;

endpackage

[rtl/core/compacting_array_table.sv]
// Top level of the compacting array table: request queue front end and list engine.
// Append, error and empty results pass through the result register and then the output register.
// Dump gives one result per cycle while the output is not held back; search scans one entry a cycle.
// Delete fetches the entry at the index, then the table shifts each later entry down, one entry a cycle.
// A two-entry request queue feeds the engine, which takes a new request only once it is back in idle.
// Reset empties the list (fill count zero); the table itself is not cleared.
`timescale 1ns / 1ps

module compacting_array_table #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_req_type,
  input  logic signed [31:0]         in_value_in,
  input  logic [cat_pkg::IDX_W-1:0]  in_index_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [cat_pkg::IDX_W-1:0]  out_index_out,
  output logic signed [31:0]         out_value_out,
  output logic                       out_last
);

  logic          cmd_valid;
  logic          cmd_ready;
  cat_pkg::cmd_t cmd;

  cat_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req_type(in_req_type),
    .in_value_in(in_value_in),
    .in_index_in(in_index_in),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  cat_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_index_out(out_index_out),
    .out_value_out(out_value_out),
    .out_last     (out_last)
  );

endmodule

[rtl/core/cat_front.sv]
// Front end: accepts requests, decodes the operation and queues them for the engine.
`timescale 1ns / 1ps

module cat_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_req_type,
  input  logic signed [31:0]         in_value_in,
  input  logic [cat_pkg::IDX_W-1:0]  in_index_in,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output cat_pkg::cmd_t              cmd
);

  cat_pkg::cmd_t                q_r [cat_pkg::Q_DEPTH];
  logic [cat_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [cat_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [cat_pkg::Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         push, pop;
  cat_pkg::cmd_t                new_cmd;

  assign in_ready  = (cnt_r != cat_pkg::Q_CNT_W'(cat_pkg::Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    new_cmd.op    = cat_pkg::op_t'(in_req_type);
    new_cmd.value = in_value_in;
    new_cmd.index = in_index_in;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + cat_pkg::Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + cat_pkg::Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + cat_pkg::Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - cat_pkg::Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cat_pkg::Q_CNT_W'(cat_pkg::Q_DEPTH))
    else $error("request queue count out of range");
`endif

endmodule

[rtl/core/cat_back.sv]
// Back end: list storage, fill count, request sequencer and result register.
`timescale 1ns / 1ps

module cat_back #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  cat_pkg::cmd_t              cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [cat_pkg::IDX_W-1:0]  out_index_out,
  output logic signed [31:0]         out_value_out,
  output logic                       out_last
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > cat_pkg::IDX_W) ? CW : cat_pkg::IDX_W) + 2;

  logic [cat_pkg::VAL_W-1:0] mem [CAPACITY];
  logic [cat_pkg::VAL_W-1:0] rd_data_r;
  logic [IW-1:0]             rd_addr;
  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;
  logic [cat_pkg::VAL_W-1:0] mem_wdata;

  cat_pkg::state_t           state_r, state_nxt;
  logic [IW-1:0]             ptr_r, ptr_nxt;
  logic [CW-1:0]             fill_r, fill_nxt;
  logic [cat_pkg::VAL_W-1:0] key_r, key_nxt;
  cat_pkg::status_t          res_status_r, res_status_nxt;
  logic [cat_pkg::IDX_W-1:0] res_index_r, res_index_nxt;
  logic [cat_pkg::VAL_W-1:0] res_value_r, res_value_nxt;

  logic                      out_valid_r, out_valid_nxt;
  cat_pkg::status_t          out_status_r, out_status_nxt;
  logic [cat_pkg::IDX_W-1:0] out_index_r, out_index_nxt;
  logic [cat_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_load;
  logic                      out_free;

  logic [XW-1:0]             ptr_x, fill_x, idx_x;
  logic [IW-1:0]             ptr_inc;
  logic                      is_empty;
  logic                      at_last;

  assign out_free  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == cat_pkg::S_IDLE);
  assign ptr_x     = XW'(ptr_r);
  assign fill_x    = XW'(fill_r);
  assign idx_x     = XW'(cmd.index);
  assign ptr_inc   = ptr_r + IW'(1);
  assign is_empty  = (fill_r == '0);
  assign at_last   = (ptr_x + XW'(1) == fill_x);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cat_pkg::S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            cat_pkg::OP_APPEND: state_nxt = cat_pkg::S_RESP;
            cat_pkg::OP_DUMP:   state_nxt = is_empty ? cat_pkg::S_RESP : cat_pkg::S_DUMP;
            cat_pkg::OP_SEARCH: state_nxt = is_empty ? cat_pkg::S_RESP : cat_pkg::S_SEARCH;
            cat_pkg::OP_DELETE: begin
              if (is_empty || idx_x >= fill_x) begin
                state_nxt = cat_pkg::S_RESP;
              end else begin
                state_nxt = cat_pkg::S_DEL_FETCH;
              end
            end
            default: state_nxt = cat_pkg::S_IDLE;
          endcase
        end
      end
      cat_pkg::S_DUMP: begin
        if (out_free && at_last) begin
          state_nxt = cat_pkg::S_IDLE;
        end
      end
      cat_pkg::S_SEARCH: begin
        if (rd_data_r == key_r || at_last) begin
          state_nxt = cat_pkg::S_RESP;
        end
      end
      cat_pkg::S_DEL_FETCH: begin
        state_nxt = at_last ? cat_pkg::S_RESP : cat_pkg::S_DEL_SHIFT;
      end
      cat_pkg::S_DEL_SHIFT: begin
        if (ptr_x + XW'(2) >= fill_x) begin
          state_nxt = cat_pkg::S_RESP;
        end
      end
      cat_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = cat_pkg::S_IDLE;
        end
      end
      default: state_nxt = cat_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    rd_addr        = ptr_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r;
    mem_wdata      = rd_data_r;
    ptr_nxt        = ptr_r;
    fill_nxt       = fill_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_value_nxt  = res_value_r;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      cat_pkg::S_IDLE: begin
        if (cmd_valid) begin
          key_nxt        = cmd.value;
          res_status_nxt = cat_pkg::STAT_EMPTY;
          res_index_nxt  = '0;
          res_value_nxt  = '0;
          unique case (cmd.op)
            cat_pkg::OP_APPEND: begin
              if (fill_x >= XW'(CAPACITY)) begin
                res_status_nxt = cat_pkg::STAT_FULL;
                res_value_nxt  = cmd.value;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = fill_r[IW-1:0];
                mem_wdata      = cmd.value;
                res_status_nxt = cat_pkg::STAT_OK;
                res_index_nxt  = fill_x[cat_pkg::IDX_W-1:0];
                res_value_nxt  = cmd.value;
                fill_nxt       = fill_r + CW'(1);
              end
            end
            cat_pkg::OP_DUMP, cat_pkg::OP_SEARCH: begin
              ptr_nxt = '0;
              rd_addr = '0;
            end
            cat_pkg::OP_DELETE: begin
              if (!is_empty && idx_x >= fill_x) begin
                res_status_nxt = cat_pkg::STAT_BADINDEX;
                res_index_nxt  = cmd.index;
              end else if (!is_empty) begin
                ptr_nxt = idx_x[IW-1:0];
                rd_addr = idx_x[IW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      cat_pkg::S_DUMP: begin
        // The entry at ptr_r is in the read register; re-read it while stalled.
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = cat_pkg::STAT_OK;
          out_index_nxt  = ptr_x[cat_pkg::IDX_W-1:0];
          out_value_nxt  = rd_data_r;
          out_last_nxt   = at_last;
          if (!at_last) begin
            ptr_nxt = ptr_inc;
            rd_addr = ptr_inc;
          end
        end
      end
      cat_pkg::S_SEARCH: begin
        if (rd_data_r == key_r) begin
          res_status_nxt = cat_pkg::STAT_OK;
          res_index_nxt  = ptr_x[cat_pkg::IDX_W-1:0];
          res_value_nxt  = key_r;
        end else if (at_last) begin
          res_status_nxt = cat_pkg::STAT_NOTFOUND;
          res_index_nxt  = '0;
          res_value_nxt  = '0;
        end else begin
          ptr_nxt = ptr_inc;
          rd_addr = ptr_inc;
        end
      end
      cat_pkg::S_DEL_FETCH: begin
        res_status_nxt = cat_pkg::STAT_OK;
        res_index_nxt  = ptr_x[cat_pkg::IDX_W-1:0];
        res_value_nxt  = rd_data_r;
        if (at_last) begin
          fill_nxt = fill_r - CW'(1);
        end else begin
          rd_addr = ptr_inc;
        end
      end
      cat_pkg::S_DEL_SHIFT: begin
        // Read register holds entry ptr_r + 1; move it down one place.
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = rd_data_r;
        if (ptr_x + XW'(2) < fill_x) begin
          ptr_nxt = ptr_inc;
          rd_addr = ptr_inc + IW'(1);
        end else begin
          fill_nxt = fill_r - CW'(1);
        end
      end
      cat_pkg::S_RESP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_index_r;
          out_value_nxt  = res_value_r;
          out_last_nxt   = 1'b1;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cat_pkg::S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_index_out = out_index_r;
  assign out_value_out = out_value_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_x <= XW'(CAPACITY))
    else $error("fill count above capacity");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == cat_pkg::S_IDLE || state_r == cat_pkg::S_DEL_SHIFT))
    else $error("table written outside append or shift");

  a_dump_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cat_pkg::S_DUMP || state_r == cat_pkg::S_SEARCH) |-> ptr_x < fill_x)
    else $error("scan pointer beyond fill count");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cat_pkg::S_DEL_SHIFT && state_nxt == cat_pkg::S_RESP)
    |=> (fill_r + CW'(1) == $past(fill_r)))
    else $error("delete did not shrink the list by one");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten while held");
`endif

endmodule

[tb/compacting_array_table_tb.sv]
// Self-checking testbench for the compacting array table: append, dump, search and delete.
`timescale 1ns / 1ps

module compacting_array_table_tb;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 40;
  localparam int PHASE_ITEMS = 85;

  typedef struct {
    cat_pkg::op_t                op;
    logic signed [31:0]          value;
    logic [cat_pkg::IDX_W-1:0]   index;
  } list_req_t;

  typedef struct {
    cat_pkg::status_t            status;
    logic [cat_pkg::IDX_W-1:0]   index;
    logic signed [31:0]          value;
    logic                        last;
  } list_resp_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  in_req_type = cat_pkg::OP_APPEND;
  logic signed [31:0]          in_value_in = '0;
  logic [cat_pkg::IDX_W-1:0]   in_index_in = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [2:0]                  out_status;
  logic [cat_pkg::IDX_W-1:0]   out_index_out;
  logic signed [31:0]          out_value_out;
  logic                        out_last;

  list_req_t  queued_requests[$];
  list_resp_t due_responses[$];
  list_req_t  offered_req;
  bit         offering = 1'b0;

  // Shadow copy of the list contents, advanced on every accepted request.
  logic signed [31:0] shadow_vals[SLOTS];
  int                 shadow_len = 0;

  // Length tracking used only while building stimulus.
  int                 gen_len = 0;
  bit                 gen_filling = 1'b1;
  logic signed [31:0] value_pool[8];

  int  send_idle_pct = 21;
  int  recv_idle_pct = 48;
  bit  hold_armed = 1'b0;
  int  hold_count = 0;
  int  cycle_count = 0;
  int  fail_count = 0;
  int  checked_count = 0;
  int  op_count[4];
  int  status_count[5];

  compacting_array_table #(.CAPACITY(SLOTS)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_value_in  (in_value_in),
    .in_index_in  (in_index_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_index_out(out_index_out),
    .out_value_out(out_value_out),
    .out_last     (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic add_response(cat_pkg::status_t st, int idx, logic signed [31:0] val,
                              bit last);
    list_resp_t r;
    r.status = st;
    r.index  = idx[cat_pkg::IDX_W-1:0];
    r.value  = val;
    r.last   = last;
    due_responses = {due_responses, r};
    status_count[st]++;
  endtask

  task automatic run_list_request(list_req_t req);
    int                 k;
    int                 hit;
    logic signed [31:0] removed;
    hit = -1;
    op_count[req.op]++;
    case (req.op)
      cat_pkg::OP_APPEND: begin
        if (shadow_len >= SLOTS) begin
          add_response(cat_pkg::STAT_FULL, 0, req.value, 1'b1);
        end else begin
          shadow_vals[shadow_len] = req.value;
          add_response(cat_pkg::STAT_OK, shadow_len, req.value, 1'b1);
          shadow_len++;
        end
      end
      cat_pkg::OP_DUMP: begin
        if (shadow_len == 0) begin
          add_response(cat_pkg::STAT_EMPTY, 0, '0, 1'b1);
        end else begin
          for (k = 0; k < shadow_len; k++)
            add_response(cat_pkg::STAT_OK, k, shadow_vals[k], k == shadow_len - 1);
        end
      end
      cat_pkg::OP_SEARCH: begin
        if (shadow_len == 0) begin
          add_response(cat_pkg::STAT_EMPTY, 0, '0, 1'b1);
        end else begin
          for (k = shadow_len - 1; k >= 0; k--)
            if (shadow_vals[k] == req.value) hit = k;
          if (hit >= 0) add_response(cat_pkg::STAT_OK, hit, req.value, 1'b1);
          else add_response(cat_pkg::STAT_NOTFOUND, 0, '0, 1'b1);
        end
      end
      default: begin
        if (shadow_len == 0) begin
          add_response(cat_pkg::STAT_EMPTY, 0, '0, 1'b1);
        end else if (req.index >= shadow_len) begin
          add_response(cat_pkg::STAT_BADINDEX, req.index, '0, 1'b1);
        end else begin
          removed = shadow_vals[req.index];
          for (k = req.index; k + 1 < shadow_len; k++)
            shadow_vals[k] = shadow_vals[k + 1];
          shadow_len--;
          add_response(cat_pkg::STAT_OK, req.index, removed, 1'b1);
        end
      end
    endcase
  endtask

  task automatic push_req(cat_pkg::op_t op, logic signed [31:0] val, int idx);
    list_req_t req;
    req.op    = op;
    req.value = val;
    req.index = idx[cat_pkg::IDX_W-1:0];
    queued_requests = {queued_requests, req};
    if (op == cat_pkg::OP_APPEND && gen_len < SLOTS) gen_len++;
    if (op == cat_pkg::OP_DELETE && gen_len > 0 && idx < gen_len) gen_len--;
  endtask

  // Mostly fill-then-drain runs with values from a small pool, so searches hit,
  // deletes land inside the list and the full and empty edges recur.
  task automatic queue_random_requests(int n);
    int                 i;
    int                 pick;
    int                 idx;
    logic signed [31:0] val;
    for (i = 0; i < n; i++) begin
      if (gen_len == SLOTS) gen_filling = 1'b0;
      else if (gen_len == 0) gen_filling = 1'b1;
      else if ($urandom_range(0, 99) < 8) gen_filling = !gen_filling;
      pick = $urandom_range(0, 99);
      idx  = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 99) < 70) val = value_pool[$urandom_range(0, 7)];
      else val = $urandom;
      if (gen_filling ? pick < 55 : pick < 15) begin
        push_req(cat_pkg::OP_APPEND, val, idx);
      end else if (gen_filling ? pick < 75 : pick < 35) begin
        push_req(cat_pkg::OP_SEARCH, val, idx);
      end else if (gen_filling ? pick < 85 : pick < 45) begin
        push_req(cat_pkg::OP_DUMP, $urandom, idx);
      end else begin
        if (gen_len > 0 && $urandom_range(0, 99) < 75) idx = $urandom_range(0, gen_len - 1);
        push_req(cat_pkg::OP_DELETE, $urandom, idx);
      end
    end
  endtask

  task automatic wait_all_accepted();
    while (queued_requests.size() != 0 || offering) @(posedge clk);
  endtask

  // Request driver: a request stays on the inputs until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!offering) begin
      if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        offered_req = queued_requests.pop_front();
        in_req_type <= offered_req.op;
        in_value_in <= offered_req.value;
        in_index_in <= offered_req.index;
        in_valid    <= 1'b1;
        offering    = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      run_list_request(offered_req);
      offering = 1'b0;
    end
  end

  // Result side: random back-pressure, plus one long hold while the sender keeps going.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_armed && hold_count < LONG_HOLD) begin
      out_ready <= 1'b0;
      hold_count++;
    end else begin
      out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    list_resp_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (due_responses.size() == 0) begin
        $error("Unexpected result: status %0d index %0d value %0d last %0d",
               out_status, out_index_out, out_value_out, out_last);
        fail_count++;
      end else begin
        exp_r = due_responses.pop_front();
        checked_count++;
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
          fail_count++;
        end
        if (out_index_out !== exp_r.index) begin
          $error("index_out: expected %0d, got %0d", exp_r.index, out_index_out);
          fail_count++;
        end
        if (out_value_out !== exp_r.value) begin
          $error("value_out: expected %0d, got %0d", exp_r.value, out_value_out);
          fail_count++;
        end
        if (out_last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, due_responses.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int i;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (status_count[i]) status_count[i] = 0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    for (i = 4; i < 8; i++) value_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty list: dump, search and delete all report empty.
    push_req(cat_pkg::OP_DUMP, 32'sd0, 0);
    push_req(cat_pkg::OP_SEARCH, 32'sh7fff_ffff, 0);
    push_req(cat_pkg::OP_DELETE, 32'sd0, 15);
    push_req(cat_pkg::OP_APPEND, 32'sh8000_0000, 15);
    push_req(cat_pkg::OP_APPEND, 32'sh7fff_ffff, 0);
    push_req(cat_pkg::OP_APPEND, 32'sd0, 0);
    push_req(cat_pkg::OP_APPEND, -32'sd1, 0);
    push_req(cat_pkg::OP_SEARCH, -32'sd1, 0);
    push_req(cat_pkg::OP_SEARCH, 32'sd12345, 0);
    // Index past the fill count is rejected; then a middle entry is removed.
    push_req(cat_pkg::OP_DELETE, 32'sd0, 15);
    push_req(cat_pkg::OP_DELETE, 32'sd0, 1);
    for (i = 0; i < 13; i++) push_req(cat_pkg::OP_APPEND, $urandom, i);
    // Full list: append is refused, then a full dump and a delete at the front.
    push_req(cat_pkg::OP_APPEND, 32'sh5a5a_5a5a, 0);
    push_req(cat_pkg::OP_DUMP, 32'sd0, 0);
    push_req(cat_pkg::OP_DELETE, 32'sd0, 0);
    queue_random_requests(PHASE_ITEMS);
    wait_all_accepted();

    send_idle_pct = 48;
    recv_idle_pct = 21;
    queue_random_requests(PHASE_ITEMS);
    wait_all_accepted();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed = 1'b1;
    queue_random_requests(PHASE_ITEMS);
    wait_all_accepted();

    while (due_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d append, %0d dump, %0d search and %0d delete requests; %0d checked.",
             op_count[cat_pkg::OP_APPEND], op_count[cat_pkg::OP_DUMP],
             op_count[cat_pkg::OP_SEARCH], op_count[cat_pkg::OP_DELETE], checked_count);
    $display("Status mix: ok %0d, empty %0d, not found %0d, bad index %0d, full %0d.",
             status_count[cat_pkg::STAT_OK], status_count[cat_pkg::STAT_EMPTY],
             status_count[cat_pkg::STAT_NOTFOUND], status_count[cat_pkg::STAT_BADINDEX],
             status_count[cat_pkg::STAT_FULL]);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
